FILE: rtl/gbu4x_pkg.sv
// ----------------------------------------------------------------------------
// gbu4x_pkg
// Shared types, gamma tables and sequencer program for the 4x upscaler.
// ----------------------------------------------------------------------------
package gbu4x_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    // Configuration registers
    localparam logic [9:0] SRC_WIDTH_RST  = 10'd256;
    localparam logic [9:0] SRC_HEIGHT_RST = 10'd224;
    localparam logic       REG_IDX_WIDTH  = 1'b0;
    localparam logic       REG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb8;

    typedef logic [31:0][7:0]  t_enc5_rom;
    typedef logic [63:0][7:0]  t_enc6_rom;
    typedef logic [255:0][7:0] t_dec_rom;

    // true when e - 1/2 <= 255 * (v/255)^(8/5), exact integer form
    function automatic logic enc_reaches(input int unsigned e, input int unsigned v);
        logic [127:0] lhs;
        logic [127:0] rhs;
        int           k;
        lhs = 128'd1;
        for (k = 0; k < 5; k++) lhs = lhs * 128'(2 * e - 1);
        for (k = 0; k < 3; k++) lhs = lhs * 128'd255;
        rhs = 128'd32;
        for (k = 0; k < 8; k++) rhs = rhs * 128'(v);
        return (lhs <= rhs);
    endfunction

    // true when e - 1/2 <= 255 * (i/255)^(5/8), exact integer form
    function automatic logic dec_reaches(input int unsigned e, input int unsigned i);
        logic [127:0] lhs;
        logic [127:0] rhs;
        int           k;
        lhs = 128'd1;
        for (k = 0; k < 8; k++) lhs = lhs * 128'(2 * e - 1);
        rhs = 128'd256;
        for (k = 0; k < 3; k++) rhs = rhs * 128'd255;
        for (k = 0; k < 5; k++) rhs = rhs * 128'(i);
        return (lhs <= rhs);
    endfunction

    function automatic t_enc5_rom build_enc5();
        t_enc5_rom   t;
        int unsigned e;
        int unsigned i;
        e = 0;
        for (i = 0; i < 32; i++) begin
            while (e < 255 && enc_reaches(e + 1, i * 8)) e++;
            t[i] = 8'(e);
        end
        return t;
    endfunction

    function automatic t_enc6_rom build_enc6();
        t_enc6_rom   t;
        int unsigned e;
        int unsigned i;
        e = 0;
        for (i = 0; i < 64; i++) begin
            while (e < 255 && enc_reaches(e + 1, i * 4)) e++;
            t[i] = 8'(e);
        end
        return t;
    endfunction

    function automatic t_dec_rom build_dec();
        t_dec_rom    t;
        int unsigned e;
        int unsigned i;
        e = 0;
        for (i = 0; i < 256; i++) begin
            while (e < 255 && dec_reaches(e + 1, i)) e++;
            t[i] = 8'(e);
        end
        return t;
    endfunction

    localparam t_enc5_rom ENC5_ROM = build_enc5();
    localparam t_enc6_rom ENC6_ROM = build_enc6();
    localparam t_dec_rom  DEC_ROM  = build_dec();

    // Expand RGB565 to gamma-1.6 linear channels; blue reuses the 5-bit table
    function automatic t_rgb8 expand(input logic [15:0] p);
        t_rgb8 c;
        c.r = ENC5_ROM[p[15:11]];
        c.g = ENC6_ROM[p[10:5]];
        c.b = ENC5_ROM[p[4:0]];
        return c;
    endfunction

    // Sequencer program
    typedef logic [2:0] t_pc;

    localparam t_pc STEP_IDLE   = 3'd0;
    localparam t_pc STEP_UPD    = 3'd1;
    localparam t_pc STEP_BASE   = 3'd2;
    localparam t_pc STEP_RIGHT  = 3'd3;
    localparam t_pc STEP_CHK    = 3'd4;
    localparam t_pc STEP_LOWER  = 3'd5;
    localparam t_pc STEP_CORNER = 3'd6;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_TILE,
        COND_NOT_LAST_COL,
        COND_NOT_LAST_ROW
    } t_cond;

    typedef struct packed {
        logic  acc;   // take a source pixel, read the line store
        logic  upd;   // expand corners, write line store, advance position
        logic  emit;  // issue sixteen tile pixels
        logic  ox;    // tile one cell to the right
        logic  oy;    // tile one cell down
        t_cond cond;  // jump condition, tested when the step completes
        t_pc   tgt;   // jump target
    } t_uop;

    function automatic t_uop uop_rom(input t_pc pc);
        t_uop u;
        u = '{acc: 1'b0, upd: 1'b0, emit: 1'b0, ox: 1'b0, oy: 1'b0,
              cond: COND_NEVER, tgt: STEP_IDLE};
        case (pc)
            STEP_IDLE: begin
                u.acc = 1'b1;
            end
            STEP_UPD: begin
                u.upd  = 1'b1;
                u.cond = COND_NO_TILE;
            end
            STEP_BASE: begin
                u.emit = 1'b1;
                u.cond = COND_NOT_LAST_COL;
                u.tgt  = STEP_CHK;
            end
            STEP_RIGHT: begin
                u.emit = 1'b1;
                u.ox   = 1'b1;
            end
            STEP_CHK: begin
                u.cond = COND_NOT_LAST_ROW;
            end
            STEP_LOWER: begin
                u.emit = 1'b1;
                u.oy   = 1'b1;
                u.cond = COND_NOT_LAST_COL;
            end
            STEP_CORNER: begin
                u.emit = 1'b1;
                u.ox   = 1'b1;
                u.oy   = 1'b1;
                u.cond = COND_ALWAYS;
            end
            default: begin
                u.acc = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/gamma_bilinear_upscale_4x_rgb565.sv
// ----------------------------------------------------------------------------
// gamma_bilinear_upscale_4x_rgb565
// Gamma-correct 4x bilinear upscaler for RGB565 video, tile-ordered output.
// ----------------------------------------------------------------------------
// Source pixels come in raster order; each pixel past the first row and column
// completes a source cell and produces a 4x4 destination tile, tagged with its
// destination coordinates, so output runs in tile order. The last column and
// last row repeat their tile to the right and below (edge clamp), so one pixel
// yields 0, 16, 32 or 64 outputs. A single blend unit issues one destination
// pixel per cycle, while the output is not stalled, into a two-register
// output path, so throughput is set by that unit; a new source pixel is
// taken only once the tiles of the last one have all been issued. A small
// microcoded sequencer steps through accept, update, a row check and one
// tile step per copy. The line store is one memory of MAX_WIDTH words with
// a registered read; its unwritten entries read as whatever they hold. Width
// and height are to be written over the register port only while the block
// is idle; the block itself does not enforce this. Values below 2 are
// treated as 2 and values above the maximum as the maximum.
// ----------------------------------------------------------------------------
module gamma_bilinear_upscale_4x_rgb565 #(
    parameter int MAX_WIDTH  = gbu4x_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gbu4x_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // source pixels
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_src_pixel,
    // destination pixels
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_dst_x,
    output logic [10:0] o_dst_y,
    output logic [15:0] o_out_pixel,
    output logic        o_run_last
);
    import gbu4x_pkg::*;

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
    localparam int SH = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [9:0]    r_src_width;
    logic [9:0]    r_src_height;
    logic [SW-1:0] w_eff;
    logic [SH-1:0] h_eff;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            REG_IDX_WIDTH:  prdata = {22'd0, r_src_width};
            REG_IDX_HEIGHT: prdata = {22'd0, r_src_height};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_src_width < 10'd2) begin
            w_eff = SW'(2);
        end else if (SW'(r_src_width) > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = SW'(r_src_width);
        end
        if (r_src_height < 10'd2) begin
            h_eff = SH'(2);
        end else if (SH'(r_src_height) > SH'(MAX_HEIGHT)) begin
            h_eff = SH'(MAX_HEIGHT);
        end else begin
            h_eff = SH'(r_src_height);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_pc  r_pc;
    t_pc  n_pc;
    t_uop uop;
    logic [3:0] r_k;
    logic [3:0] n_k;
    logic       step_done;
    logic       jump;
    logic       issue;
    logic       accept;

    // position and per-item state
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [15:0]   r_left_pix;
    logic [15:0]   r_ul_pix;
    logic [15:0]   r_pix;
    logic [CW-1:0] r_c;
    logic [RW-1:0] r_r;
    logic          r_no_tile;
    logic          r_last_col;
    logic          r_last_row;
    t_rgb8         r_cn [4];

    // line store
    logic [15:0]   mem [MAX_WIDTH];
    logic [15:0]   r_rd_data;

    // blend and output stages
    logic          r_s1_valid;
    logic [7:0]    r_s1_r;
    logic [7:0]    r_s1_g;
    logic [7:0]    r_s1_b;
    logic [10:0]   r_s1_x;
    logic [10:0]   r_s1_y;
    logic          r_s1_last;
    logic          r_out_valid;
    logic [10:0]   r_out_x;
    logic [10:0]   r_out_y;
    logic [15:0]   r_out_pixel;
    logic          r_out_last;
    logic          out_free;
    logic          s1_free;

    assign uop        = uop_rom(r_pc);
    assign o_in_stall = !uop.acc;
    assign accept     = uop.acc && i_in_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign issue      = uop.emit && s1_free;

    always_comb begin
        step_done = 1'b1;
        if (uop.acc) begin
            step_done = i_in_valid;
        end else if (uop.emit) begin
            step_done = issue && (r_k == 4'hF);
        end
        case (uop.cond)
            COND_NEVER:        jump = 1'b0;
            COND_ALWAYS:       jump = 1'b1;
            COND_NO_TILE:      jump = r_no_tile;
            COND_NOT_LAST_COL: jump = !r_last_col;
            COND_NOT_LAST_ROW: jump = !r_last_row;
            default:           jump = 1'b0;
        endcase
        n_pc = r_pc;
        if (step_done) begin
            n_pc = jump ? uop.tgt : t_pc'(r_pc + 3'd1);
        end
        n_k = issue ? r_k + 4'd1 : r_k;
    end

    // ------------------------------------------------------------------
    // Position: wrap on accept, advance on update
    // ------------------------------------------------------------------
    logic          col_ovf;
    logic [RW:0]   row_a;
    logic [CW-1:0] cur_c;
    logic [RW-1:0] cur_r;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;

    always_comb begin
        col_ovf = SW'(r_col) >= w_eff;
        row_a   = col_ovf ? {1'b0, r_row} + (RW+1)'(1) : {1'b0, r_row};
        cur_c   = col_ovf ? '0 : r_col;
        cur_r   = (SH'(row_a) >= h_eff) ? '0 : row_a[RW-1:0];

        col_inc = {1'b0, r_c} + (CW+1)'(1);
        row_inc = {1'b0, r_r} + (RW+1)'(1);
        if (SW'(col_inc) >= w_eff) begin
            n_col = '0;
            n_row = (SH'(row_inc) >= h_eff) ? '0 : row_inc[RW-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = r_r;
        end
    end

    // ------------------------------------------------------------------
    // Blend unit
    // ------------------------------------------------------------------
    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d,
                                         input logic [4:0] wa, input logic [4:0] wb,
                                         input logic [4:0] wc, input logic [4:0] wd);
        logic [11:0] s;
        s = 12'(a) * 12'(wa) + 12'(b) * 12'(wb) + 12'(c) * 12'(wc)
          + 12'(d) * 12'(wd) + 12'd8;
        return s[11:4];
    endfunction

    logic [1:0]    kx;
    logic [1:0]    ky;
    logic [4:0]    ix;
    logic [4:0]    iy;
    logic [4:0]    fx;
    logic [4:0]    fy;
    logic [4:0]    wa;
    logic [4:0]    wb;
    logic [4:0]    wc;
    logic [4:0]    wd;
    logic [CW-1:0] x_cell;
    logic [RW-1:0] y_cell;
    logic          more_tiles;

    always_comb begin
        kx = r_k[1:0];
        ky = r_k[3:2];
        fx = {3'd0, kx};
        fy = {3'd0, ky};
        ix = 5'd4 - fx;
        iy = 5'd4 - fy;
        wa = 5'(ix * iy);
        wb = 5'(fx * iy);
        wc = 5'(ix * fy);
        wd = 5'(fx * fy);
        x_cell = uop.ox ? r_c : r_c - CW'(1);
        y_cell = uop.oy ? r_r : r_r - RW'(1);
        // copies still to come after the tile in progress
        if (uop.oy) begin
            more_tiles = !uop.ox && r_last_col;
        end else if (uop.ox) begin
            more_tiles = r_last_row;
        end else begin
            more_tiles = r_last_col || r_last_row;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= STEP_IDLE;
            r_k          <= 4'd0;
            r_src_width  <= SRC_WIDTH_RST;
            r_src_height <= SRC_HEIGHT_RST;
            r_col        <= '0;
            r_row        <= '0;
            r_left_pix   <= 16'd0;
            r_ul_pix     <= 16'd0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc <= n_pc;
            r_k  <= n_k;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_IDX_WIDTH:  r_src_width  <= pwdata[9:0];
                    REG_IDX_HEIGHT: r_src_height <= pwdata[9:0];
                    default:        r_src_width  <= r_src_width;
                endcase
            end
            if (uop.upd) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_left_pix <= r_pix;
                r_ul_pix   <= r_rd_data;
            end
            if (s1_free) begin
                r_s1_valid <= issue;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Item payload, corners and pipeline data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix      <= i_src_pixel;
            r_c        <= cur_c;
            r_r        <= cur_r;
            r_no_tile  <= (cur_c == '0) || (cur_r == '0);
            r_last_col <= (SW'(cur_c) == w_eff - SW'(1));
            r_last_row <= (SH'(cur_r) == h_eff - SH'(1));
        end
        if (uop.upd) begin
            r_cn[0] <= expand(r_ul_pix);
            r_cn[1] <= expand(r_rd_data);
            r_cn[2] <= expand(r_left_pix);
            r_cn[3] <= expand(r_pix);
        end
        if (issue) begin
            r_s1_r    <= blend(r_cn[0].r, r_cn[1].r, r_cn[2].r, r_cn[3].r, wa, wb, wc, wd);
            r_s1_g    <= blend(r_cn[0].g, r_cn[1].g, r_cn[2].g, r_cn[3].g, wa, wb, wc, wd);
            r_s1_b    <= blend(r_cn[0].b, r_cn[1].b, r_cn[2].b, r_cn[3].b, wa, wb, wc, wd);
            r_s1_x    <= 11'({x_cell, kx});
            r_s1_y    <= 11'({y_cell, ky});
            r_s1_last <= (r_k == 4'hF) && !more_tiles;
        end
        if (r_s1_valid && out_free) begin
            r_out_x     <= r_s1_x;
            r_out_y     <= r_s1_y;
            r_out_pixel <= {DEC_ROM[r_s1_r][7:3], DEC_ROM[r_s1_g][7:2],
                            DEC_ROM[r_s1_b][7:3]};
            r_out_last  <= r_s1_last;
        end
    end

    // line store: read on accept, write back on update
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[cur_c];
        end
        if (uop.upd) begin
            mem[r_c] <= r_pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dst_x     = r_out_x;
    assign o_dst_y     = r_out_y;
    assign o_out_pixel = r_out_pixel;
    assign o_run_last  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_pc == STEP_UPD))
        else $error("accepted pixel not followed by the update step");

    a_last_closes_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> (r_s1_x[1:0] == 2'b11 && r_s1_y[1:0] == 2'b11))
        else $error("run end marked inside a tile");

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_UPD) |-> (SW'(n_col) < w_eff))
        else $error("next column beyond the effective width");

    a_issue_needs_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> !r_no_tile)
        else $error("tile issued for a first-row or first-column pixel");

endmodule
